// File: hw/rtl/i2c_master_byte_write_core_assert.svh
// Assertion macros used by the top RTL file of the I2C byte write core.
// With SYNTH defined, every macro expands to nothing.
`ifndef I2C_MASTER_BYTE_WRITE_CORE_ASSERT_SVH
`define I2C_MASTER_BYTE_WRITE_CORE_ASSERT_SVH

`ifndef SYNTH

// Checks that a property holds on every rising clock edge outside reset.
`define I2CMBW_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("i2cmbw assertion failed");

// Checks that the consequent holds in the same cycle as the antecedent.
`define I2CMBW_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("i2cmbw implication failed");

`else

`define I2CMBW_ASSERT(lbl, clk, rst_n, prop)
`define I2CMBW_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: hw/rtl/i2cmbw_pkg.sv
package i2cmbw_pkg;

  // Bus phases of one byte write transfer.
  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_START_HI   = 4'd1,
    PH_START_FALL = 4'd2,
    PH_START_LOW  = 4'd3,
    PH_BIT_LOW    = 4'd4,
    PH_BIT_HIGH   = 4'd5,
    PH_ACK_LOW    = 4'd6,
    PH_ACK_HIGH   = 4'd7,
    PH_STOP_LOW   = 4'd8,
    PH_STOP_HIGH  = 4'd9,
    PH_STOP_RISE  = 4'd10
  } phase_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_DEV_ADDR  = 2'd0,
    REG_WORD_ADDR = 2'd1,
    REG_WR_DATA   = 2'd2
  } reg_idx_e;

  localparam logic [7:0] DevAddrReset  = 8'hA0;
  localparam logic [7:0] WordAddrReset = 8'hBA;
  localparam logic [7:0] WrDataReset   = 8'hC5;

  localparam logic [3:0] BitsPerByte   = 4'd8;
  localparam logic [1:0] LastByteIdx   = 2'd2;

  // The three bytes of one transfer.
  typedef struct packed {
    logic [7:0] dev_addr;
    logic [7:0] word_addr;
    logic [7:0] wr_data;
  } cfg_t;

  // Drive levels and status of one tick.
  typedef struct packed {
    logic       scl_level;
    logic       sda_drive_low;
    logic       busy_res;
    logic       ack_valid;
    logic       ack_received;
    logic [1:0] byte_number;
    logic       transfer_done;
  } tick_res_t;

endpackage

// File: hw/rtl/i2cmbw_seq.sv
module i2cmbw_seq (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic                  go_i,
  input  logic                  sda_level_i,
  input  i2cmbw_pkg::cfg_t      cfg_i,
  output i2cmbw_pkg::tick_res_t res_o
);
  import i2cmbw_pkg::*;

  phase_e     phase_q, phase_d;
  logic [3:0] bit_cnt_q, bit_cnt_d;
  logic [7:0] shift_q, shift_d;
  logic [1:0] byte_idx_q, byte_idx_d;
  phase_e     cur_phase;
  logic [3:0] bit_cnt_inc;
  logic [1:0] byte_idx_inc;

  function automatic logic [7:0] byte_for(input logic [1:0] idx, input cfg_t cfg);
    logic [7:0] b;
    case (idx)
      REG_DEV_ADDR:  b = cfg.dev_addr;
      REG_WORD_ADDR: b = cfg.word_addr;
      default:       b = cfg.wr_data;
    endcase
    return b;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      bit_cnt_q  <= '0;
      shift_q    <= '0;
      byte_idx_q <= '0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      bit_cnt_q  <= bit_cnt_d;
      shift_q    <= shift_d;
      byte_idx_q <= byte_idx_d;
    end
  end

  assign bit_cnt_inc  = bit_cnt_q + 4'd1;
  assign byte_idx_inc = byte_idx_q + 2'd1;

  always_comb begin
    // A go request while idle already plays the first start tick.
    cur_phase = phase_q;
    if (phase_q == PH_IDLE && go_i) begin
      cur_phase = PH_START_HI;
    end

    phase_d    = PH_IDLE;
    bit_cnt_d  = bit_cnt_q;
    shift_d    = shift_q;
    byte_idx_d = byte_idx_q;
    res_o      = '0;
    res_o.scl_level = 1'b1;
    res_o.busy_res  = 1'b1;

    unique case (cur_phase)
      PH_START_HI: begin
        phase_d = PH_START_FALL;
      end
      PH_START_FALL: begin
        res_o.sda_drive_low = 1'b1;
        phase_d = PH_START_LOW;
      end
      PH_START_LOW: begin
        res_o.scl_level     = 1'b0;
        res_o.sda_drive_low = 1'b1;
        byte_idx_d = '0;
        bit_cnt_d  = '0;
        shift_d    = cfg_i.dev_addr;
        phase_d    = PH_BIT_LOW;
      end
      PH_BIT_LOW: begin
        res_o.scl_level     = 1'b0;
        res_o.sda_drive_low = ~shift_q[7];
        phase_d = PH_BIT_HIGH;
      end
      PH_BIT_HIGH: begin
        res_o.sda_drive_low = ~shift_q[7];
        shift_d   = {shift_q[6:0], 1'b0};
        bit_cnt_d = bit_cnt_inc;
        phase_d   = (bit_cnt_inc >= BitsPerByte) ? PH_ACK_LOW : PH_BIT_LOW;
      end
      PH_ACK_LOW: begin
        res_o.scl_level = 1'b0;
        phase_d = PH_ACK_HIGH;
      end
      PH_ACK_HIGH: begin
        res_o.ack_valid    = 1'b1;
        res_o.ack_received = ~sda_level_i;
        res_o.byte_number  = byte_idx_q;
        if (byte_idx_q >= LastByteIdx) begin
          phase_d = PH_STOP_LOW;
        end else begin
          // The next byte is taken from its register only now.
          byte_idx_d = byte_idx_inc;
          bit_cnt_d  = '0;
          shift_d    = byte_for(byte_idx_inc, cfg_i);
          phase_d    = PH_BIT_LOW;
        end
      end
      PH_STOP_LOW: begin
        res_o.scl_level     = 1'b0;
        res_o.sda_drive_low = 1'b1;
        phase_d = PH_STOP_HIGH;
      end
      PH_STOP_HIGH: begin
        res_o.sda_drive_low = 1'b1;
        phase_d = PH_STOP_RISE;
      end
      PH_STOP_RISE: begin
        res_o.transfer_done = 1'b1;
        bit_cnt_d  = '0;
        byte_idx_d = '0;
        phase_d    = PH_IDLE;
      end
      default: begin
        // Idle, and any code outside the phase list, releases the bus.
        res_o.busy_res = 1'b0;
        phase_d = PH_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/i2c_master_byte_write_core.sv
// Bit-level I2C master that writes one byte to a slave. Every input request is
// one bus timing tick (about 12 us) and produces exactly one result request
// with the SCL level and SDA pull-down to drive for that tick, plus status.
// A request with go set while idle starts a transfer on that very tick: a
// start condition, then the device write address, the word address and the
// data byte, each sent MSB first and followed by an acknowledge clock on which SDA
// is released and the acknowledge is sampled (ack_valid_o, ack_received_o,
// byte_number_o). A NACK is reported but the transfer goes on. A stop
// condition ends it, with transfer_done_o on its last tick. A whole transfer
// takes 60 ticks; go is ignored while busy. The block takes one tick per
// clock cycle unless the full output register is not taken; phase register and
// byte shifter update on each accepted tick, and the result sits in one output
// register, refilled in the same cycle it is taken. Each byte is loaded from
// its configuration register when that byte begins, so the registers are
// best written while no transfer runs. Writes to index 3 are ignored.
module i2c_master_byte_write_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Tick input channel.
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       go_i,
  input  logic       sda_level_i,
  // Tick result channel.
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       scl_level_o,
  output logic       sda_drive_low_o,
  output logic       busy_res_o,
  output logic       ack_valid_o,
  output logic       ack_received_o,
  output logic [1:0] byte_number_o,
  output logic       transfer_done_o,
  // Configuration write channel.
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);
  import i2cmbw_pkg::*;

`include "i2c_master_byte_write_core_assert.svh"

  cfg_t      cfg_q;
  tick_res_t tick_res;
  tick_res_t res_q;
  logic      out_valid_q;
  logic      in_accept;
  logic      cfg_accept;

  // A new tick is taken whenever the output register is empty or is being
  // emptied in this cycle.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_accept  = in_valid_i && in_ready_o;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;
  assign cfg_accept  = cfg_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dev_addr  <= DevAddrReset;
      cfg_q.word_addr <= WordAddrReset;
      cfg_q.wr_data   <= WrDataReset;
    end else if (cfg_accept) begin
      unique case (cfg_index_i)
        REG_DEV_ADDR:  cfg_q.dev_addr  <= cfg_data_i;
        REG_WORD_ADDR: cfg_q.word_addr <= cfg_data_i;
        REG_WR_DATA:   cfg_q.wr_data   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The sequencer advances one phase per accepted tick and tells what the
  // bus lines do on that tick.
  i2cmbw_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (in_accept),
    .go_i        (go_i),
    .sda_level_i (sda_level_i),
    .cfg_i       (cfg_q),
    .res_o       (tick_res)
  );

  // Result register: valid is control state, the payload needs no reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      res_q <= tick_res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign scl_level_o     = res_q.scl_level;
  assign sda_drive_low_o = res_q.sda_drive_low;
  assign busy_res_o      = res_q.busy_res;
  assign ack_valid_o     = res_q.ack_valid;
  assign ack_received_o  = res_q.ack_received;
  assign byte_number_o   = res_q.byte_number;
  assign transfer_done_o = res_q.transfer_done;

  // The acknowledge is sampled only with SCL high and SDA released.
  `I2CMBW_ASSERT_IMPL(a_ack_bus, clk_i, rst_ni, out_valid_o && ack_valid_o, scl_level_o && !sda_drive_low_o)
  // The final stop tick still counts as part of the transfer.
  `I2CMBW_ASSERT_IMPL(a_done_busy, clk_i, rst_ni, out_valid_o && transfer_done_o, busy_res_o && scl_level_o)
  // A byte number is reported only with an acknowledge.
  `I2CMBW_ASSERT_IMPL(a_bnum_ack, clk_i, rst_ni, out_valid_o && byte_number_o != 2'd0, ack_valid_o)
  // An idle tick never drives the bus.
  `I2CMBW_ASSERT(a_idle_release, clk_i, rst_ni, !(out_valid_o && !busy_res_o) || (scl_level_o && !sda_drive_low_o && !ack_valid_o))

endmodule

// File: bench/i2c_byte_write_checker.sv
module i2c_byte_write_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic       go_i,
  input  logic       sda_level_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic       scl_level_i,
  input  logic       sda_drive_low_i,
  input  logic       busy_res_i,
  input  logic       ack_valid_i,
  input  logic       ack_received_i,
  input  logic [1:0] byte_number_i,
  input  logic       transfer_done_i,
  input  logic       cfg_valid_i,
  input  logic       cfg_ready_i,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  output int         fail_cnt_o,
  output int         outstanding_o,
  output int         ticks_checked_o,
  output int         transfers_o,
  output int         nacks_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import i2cmbw_pkg::*;

  // Shadow copy of the block's configuration and bus sequencer.
  cfg_t       regs = {DevAddrReset, WordAddrReset, WrDataReset};
  phase_e     bus_phase = PH_IDLE;
  logic [3:0] bit_cnt = '0;
  logic [7:0] shifter = '0;
  logic [1:0] byte_idx = '0;

  tick_res_t  expected_ticks[$];
  int         errors = 0;
  int         checked = 0;
  int         transfers = 0;
  int         nacks = 0;

  // Advances the shadow sequencer by one tick and returns what the bus should show.
  function automatic tick_res_t bus_tick(input logic go, input logic sda_in);
    tick_res_t r;
    logic      sda_rel;
    r = '0;
    r.scl_level = 1'b1;
    r.busy_res = 1'b1;
    sda_rel = 1'b1;
    if (bus_phase == PH_IDLE && go) bus_phase = PH_START_HI;
    case (bus_phase)
      PH_START_HI: begin
        bus_phase = PH_START_FALL;
      end
      PH_START_FALL: begin
        sda_rel = 1'b0;
        bus_phase = PH_START_LOW;
      end
      PH_START_LOW: begin
        r.scl_level = 1'b0;
        sda_rel = 1'b0;
        byte_idx = '0;
        bit_cnt = '0;
        shifter = regs.dev_addr;
        bus_phase = PH_BIT_LOW;
      end
      PH_BIT_LOW: begin
        r.scl_level = 1'b0;
        sda_rel = shifter[7];
        bus_phase = PH_BIT_HIGH;
      end
      PH_BIT_HIGH: begin
        sda_rel = shifter[7];
        shifter = shifter << 1;
        bit_cnt = bit_cnt + 4'd1;
        bus_phase = (bit_cnt >= BitsPerByte) ? PH_ACK_LOW : PH_BIT_LOW;
      end
      PH_ACK_LOW: begin
        r.scl_level = 1'b0;
        bus_phase = PH_ACK_HIGH;
      end
      PH_ACK_HIGH: begin
        r.ack_valid = 1'b1;
        r.ack_received = ~sda_in;
        r.byte_number = byte_idx;
        if (byte_idx >= LastByteIdx) begin
          bus_phase = PH_STOP_LOW;
        end else begin
          byte_idx = byte_idx + 2'd1;
          bit_cnt = '0;
          shifter = (byte_idx == LastByteIdx) ? regs.wr_data : regs.word_addr;
          bus_phase = PH_BIT_LOW;
        end
      end
      PH_STOP_LOW: begin
        r.scl_level = 1'b0;
        sda_rel = 1'b0;
        bus_phase = PH_STOP_HIGH;
      end
      PH_STOP_HIGH: begin
        sda_rel = 1'b0;
        bus_phase = PH_STOP_RISE;
      end
      PH_STOP_RISE: begin
        r.transfer_done = 1'b1;
        bit_cnt = '0;
        byte_idx = '0;
        bus_phase = PH_IDLE;
      end
      default: begin
        r.busy_res = 1'b0;
        bus_phase = PH_IDLE;
      end
    endcase
    r.sda_drive_low = ~sda_rel;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [1:0] want, input logic [1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    tick_res_t want;
    tick_res_t got;
    if (!rst_ni) begin
      regs = {DevAddrReset, WordAddrReset, WrDataReset};
      bus_phase = PH_IDLE;
      bit_cnt = '0;
      shifter = '0;
      byte_idx = '0;
      expected_ticks.delete();
    end else begin
      // Results are registered, so the one leaving now never belongs to the
      // request entering at the same edge.
      if (out_valid_i && out_ready_i) begin
        got = {scl_level_i, sda_drive_low_i, busy_res_i, ack_valid_i, ack_received_i,
               byte_number_i, transfer_done_i};
        if (expected_ticks.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
          errors++;
        end else begin
          want = expected_ticks.pop_front();
          check_field("scl_level", want.scl_level, got.scl_level);
          check_field("sda_drive_low", want.sda_drive_low, got.sda_drive_low);
          check_field("busy_res", want.busy_res, got.busy_res);
          check_field("ack_valid", want.ack_valid, got.ack_valid);
          check_field("ack_received", want.ack_received, got.ack_received);
          check_field("byte_number", want.byte_number, got.byte_number);
          check_field("transfer_done", want.transfer_done, got.transfer_done);
          checked++;
        end
      end
      if (in_valid_i && in_ready_i) begin
        want = bus_tick(go_i, sda_level_i);
        if (want.transfer_done) transfers++;
        if (want.ack_valid && !want.ack_received) nacks++;
        expected_ticks.push_back(want);
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (reg_idx_e'(cfg_index_i))
          REG_DEV_ADDR:  regs.dev_addr = cfg_data_i;
          REG_WORD_ADDR: regs.word_addr = cfg_data_i;
          REG_WR_DATA:   regs.wr_data = cfg_data_i;
          default: ;
        endcase
      end
    end
    fail_cnt_o <= errors;
    outstanding_o <= expected_ticks.size();
    ticks_checked_o <= checked;
    transfers_o <= transfers;
    nacks_o <= nacks;
  end

endmodule

// File: bench/i2c_master_byte_write_core_tb.sv
module i2c_master_byte_write_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cmbw_pkg::*;

  // One transfer is a fixed number of bus ticks from the go tick to the
  // done tick, inclusive.
  localparam int TransferTicks = 60;
  // Random ticks per register setting, and the number of settings.
  localparam int PhaseTicks = 320;
  localparam int NumSettings = 6;
  // Percentage of cycles in which either side idles.
  localparam int IdlePct = 11;
  // The receiver holds off once, after this many checked results.
  localparam int RxHoldAt = 500;
  localparam int RxHoldCycles = 150;
  // The sender pauses to drain the block once, partway into this setting.
  localparam int PauseSetting = 2;
  localparam int PauseAfter = 160;
  // The setting that runs with no random idling on either side.
  localparam int BusySetting = 1;
  // Cycles without any accepted request before the run is abandoned.
  localparam int WatchdogLimit = 2000;
  // The one register index the block does not decode.
  localparam logic [1:0] RegUnused = 2'd3;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic       go;
  logic       sda_level;
  logic       out_valid;
  logic       out_ready;
  logic       scl_level;
  logic       sda_drive_low;
  logic       busy_res;
  logic       ack_valid;
  logic       ack_received;
  logic [1:0] byte_number;
  logic       transfer_done;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  int fail_cnt;
  int outstanding;
  int ticks_checked;
  int transfers;
  int nacks;

  // Both stimulus processes read this flag; it is updated on a clock edge so
  // they see the same value.
  logic no_idle;
  // Ticks left in the transfer the sender believes is running. The sender
  // mirrors the transfer length so that most go requests land on idle ticks.
  int   busy_left = 0;
  int   idle_cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  i2c_master_byte_write_core dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .go_i           (go),
    .sda_level_i    (sda_level),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .scl_level_o    (scl_level),
    .sda_drive_low_o(sda_drive_low),
    .busy_res_o     (busy_res),
    .ack_valid_o    (ack_valid),
    .ack_received_o (ack_received),
    .byte_number_o  (byte_number),
    .transfer_done_o(transfer_done),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  i2c_byte_write_checker checker_inst (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .go_i           (go),
    .sda_level_i    (sda_level),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .scl_level_i    (scl_level),
    .sda_drive_low_i(sda_drive_low),
    .busy_res_i     (busy_res),
    .ack_valid_i    (ack_valid),
    .ack_received_i (ack_received),
    .byte_number_i  (byte_number),
    .transfer_done_i(transfer_done),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .fail_cnt_o     (fail_cnt),
    .outstanding_o  (outstanding),
    .ticks_checked_o(ticks_checked),
    .transfers_o    (transfers),
    .nacks_o        (nacks)
  );

  // Offers one tick request, after an optional random gap, and returns at the
  // edge where it is accepted. Valid is left high so the next request can
  // follow without a bubble.
  task automatic send_tick(input logic g, input logic s);
    while (!no_idle && $urandom_range(99) < IdlePct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    go <= g;
    sda_level <= s;
    do @(posedge clk); while (!in_ready);
    if (busy_left == 0 && g) busy_left = TransferTicks;
    if (busy_left != 0) busy_left--;
  endtask

  // Stops offering ticks and waits until every expected result has arrived.
  // The first edge is always taken, because the outstanding count shown at
  // the current edge does not yet include a request accepted at it.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Writes one configuration register. Valid stays high for a following
  // write; the caller lowers it after the last one.
  task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Main stimulus: a directed opening under the reset register values, then
  // one random phase per register setting.
  initial begin
    cfg_t settings[NumSettings];
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    go <= 1'b0;
    sda_level <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_DEV_ADDR;
    cfg_data <= '0;
    no_idle <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // All-zero and all-one bytes are the extremes; the third setting puts
    // alternating bits and a lone high bit on the wire, the rest are random.
    settings[0] = '0;
    settings[1] = '1;
    settings[2] = {8'h55, 8'hAA, 8'h01};
    for (int i = 3; i < NumSettings; i++) begin
      settings[i] = {8'($urandom), 8'($urandom), 8'($urandom)};
    end

    // Idle ticks with both line levels, then go held high for a whole
    // transfer: go while busy must be ignored, and the tick after the done
    // tick starts the next transfer back to back. SDA is low on the first
    // acknowledge and high on the others, so both ACK and NACK show up.
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    for (int k = 1; k <= TransferTicks + 1; k++) begin
      send_tick(1'b1, k > TransferTicks / 2);
    end

    for (int p = 0; p < NumSettings; p++) begin
      // Registers are only written once the block has handed back all results.
      drain();
      write_reg(REG_DEV_ADDR, settings[p].dev_addr);
      write_reg(REG_WORD_ADDR, settings[p].word_addr);
      write_reg(REG_WR_DATA, settings[p].wr_data);
      // A write to the undecoded index must change nothing; it carries all
      // ones while the real registers hold all zeros.
      if (p == 0) write_reg(RegUnused, 8'hFF);
      cfg_valid <= 1'b0;
      no_idle <= (p == BusySetting);

      for (int n = 0; n < PhaseTicks; n++) begin
        if (p == PauseSetting && n == PauseAfter) drain();
        // Mostly well-formed traffic: go on idle ticks starts a transfer,
        // and the slave usually acknowledges. Idle noise, go while busy and
        // NACKs are mixed in.
        if (busy_left == 0) begin
          send_tick($urandom_range(99) < 70, 1'($urandom_range(1)));
        end else begin
          send_tick($urandom_range(99) < 25, $urandom_range(99) < 15);
        end
      end
    end

    drain();
    repeat (4) @(posedge clk);
    $display("Covered %0d ticks under %0d register settings plus the reset values:",
             ticks_checked, NumSettings);
    $display("  %0d transfers, %0d NACKed bytes, one long receiver stall, one drain pause.",
             transfers, nacks);
    if (fail_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Result side: random back-pressure, plus one long hold-off during which
  // the sender keeps offering ticks, so the output register fills and the
  // block has to stall its input.
  initial begin
    bit held;
    held = 1'b0;
    out_ready <= 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (!held && ticks_checked >= RxHoldAt) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (RxHoldCycles) @(posedge clk);
      end
      out_ready <= no_idle || ($urandom_range(99) >= IdlePct);
    end
  end

  // Watchdog: any accepted request on any channel counts as progress.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
        $display("Timeout after %0d cycles without progress, %0d results outstanding",
                 idle_cycles, outstanding);
        $display("Simulation FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule
